@@ sv/mchw_pkg.sv @@
`timescale 1ns / 1ps

package mchw_pkg;

  // Channel count limits
  localparam int MaxCh          = 3;
  localparam int DefNumChannels = 3;

  // Field widths
  localparam int MsW     = 24;
  localparam int LenW    = 6;
  localparam int MaskW   = 3;
  localparam int CycW    = 8;
  localparam int ChIdxW  = 2;
  localparam int CfgAddrW = 3;

  // Packed stream widths, padded to whole bytes
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  localparam logic [MsW-1:0] MsMax = '1;

  // Register reset values
  localparam logic [MsW-1:0] AckTimeoutRst = 24'd300000;
  localparam logic [MsW-1:0] PowerWaitRst  = 24'd120000;
  localparam logic [MsW-1:0] AwayLimitRst  = 24'd15999;
  localparam logic [MsW-1:0] IdARst        = 24'h474747;
  localparam logic [MsW-1:0] IdBRst        = 24'h434343;
  localparam logic [MsW-1:0] IdCRst        = 24'h535353;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegAckTimeout = 3'd0;
  localparam logic [CfgAddrW-1:0] RegPowerWait  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegAwayLimit  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegIdA        = 3'd3;
  localparam logic [CfgAddrW-1:0] RegIdB        = 3'd4;
  localparam logic [CfgAddrW-1:0] RegIdC        = 3'd5;

  // Request kinds
  localparam logic ReqTick      = 1'b0;
  localparam logic ReqHeartbeat = 1'b1;

  // One input request
  typedef struct packed {
    logic [MaskW-1:0] hold_mask;
    logic [LenW-1:0]  msg_len;
    logic [MsW-1:0]   msg_id;
    logic             req_type;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [CycW-1:0]   cycles_ch2;
    logic [CycW-1:0]   cycles_ch1;
    logic [CycW-1:0]   cycles_ch0;
    logic [MaskW-1:0]  away_mask;
    logic [MaskW-1:0]  rebooting_mask;
    logic [MaskW-1:0]  power_cycle_mask;
    logic [ChIdxW-1:0] hb_channel;
    logic              hb_matched;
  } out_item_t;

endpackage

@@ sv/multi_channel_heartbeat_watchdog_top.sv @@
`timescale 1ns / 1ps

// A request is registered in stage 1 on acceptance; its result is registered in the result
// register when stage 1 advances, which waits while a full result register is not drained.
// Throughput: one request per cycle while the result channel is not stalled; the channel
// state update is a single pass of logic. Reset (rst_n low, synchronous): channel state
// clears, registers take their defaults, and both pipeline stages empty.
module multi_channel_heartbeat_watchdog_top #(
  parameter int NUM_CHANNELS = mchw_pkg::DefNumChannels
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [mchw_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [mchw_pkg::MsW-1:0]       cfg_wdata,
  // Request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata fields from bit 0: msg_id[23:0], msg_len[29:24], hold_mask[32:30], zero pad
  input  logic [mchw_pkg::InDataW-1:0]   in_tdata,
  // tuser fields from bit 0: req_type
  input  logic                           in_tuser,
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata fields from bit 0: hb_matched, hb_channel[2:1], power_cycle_mask[5:3],
  // rebooting_mask[8:6], away_mask[11:9], cycles_ch0[19:12], cycles_ch1[27:20],
  // cycles_ch2[35:28], zero pad
  output logic [mchw_pkg::OutDataW-1:0]  out_tdata
);
  import mchw_pkg::*;

  localparam int OutUsedW = $bits(out_item_t);

  // Configuration registers
  logic [MsW-1:0] ack_timeout_r;
  logic [MsW-1:0] power_wait_r;
  logic [MsW-1:0] away_limit_r;
  logic [MsW-1:0] chan_id_r [MaxCh];

  // Channel state
  logic [MsW-1:0]  since_ack_r  [NUM_CHANNELS];
  logic [MsW-1:0]  since_ack_nxt[NUM_CHANNELS];
  logic [MsW-1:0]  wait_left_r  [NUM_CHANNELS];
  logic [MsW-1:0]  wait_left_nxt[NUM_CHANNELS];
  logic [CycW-1:0] cycle_cnt_r  [NUM_CHANNELS];
  logic [CycW-1:0] cycle_cnt_nxt[NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] reboot_r;
  logic [NUM_CHANNELS-1:0] reboot_nxt;

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      s1_adv;

  // Flow control: stage 1 moves on when the result register is free or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-OutUsedW){1'b0}}, out_item_r};

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= AckTimeoutRst;
      power_wait_r  <= PowerWaitRst;
      away_limit_r  <= AwayLimitRst;
      chan_id_r[0]  <= IdARst;
      chan_id_r[1]  <= IdBRst;
      chan_id_r[2]  <= IdCRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegAckTimeout: ack_timeout_r <= cfg_wdata;
        RegPowerWait:  power_wait_r  <= cfg_wdata;
        RegAwayLimit:  away_limit_r  <= cfg_wdata;
        RegIdA:        chan_id_r[0]  <= cfg_wdata;
        RegIdB:        chan_id_r[1]  <= cfg_wdata;
        RegIdC:        chan_id_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= in_item_t'({in_tdata[32:0], in_tuser});
    end
  end

  // Channel update and result for the request in stage 1
  always_comb begin
    logic [MsW-1:0]   inc;
    logic [MsW-1:0]   wdec;
    logic             found;
    logic [MaskW-1:0] pulse;
    logic [MaskW-1:0] reb;
    logic [MaskW-1:0] away;
    logic [CycW-1:0]  cyc [MaxCh];
    logic [ChIdxW-1:0] which;

    found = 1'b0;
    which = '0;
    pulse = '0;
    reb   = '0;
    away  = '0;
    for (int c = 0; c < MaxCh; c++) cyc[c] = '0;

    for (int c = 0; c < NUM_CHANNELS; c++) begin
      since_ack_nxt[c] = since_ack_r[c];
      wait_left_nxt[c] = wait_left_r[c];
      cycle_cnt_nxt[c] = cycle_cnt_r[c];
      reboot_nxt[c]    = reboot_r[c];
      inc  = (since_ack_r[c] == MsMax) ? since_ack_r[c] : since_ack_r[c] + 1'b1;
      wdec = (wait_left_r[c] <= MsW'(1)) ? '0 : wait_left_r[c] - 1'b1;

      if (s1_item_r.req_type == ReqTick) begin
        if (s1_item_r.hold_mask[c]) begin
          // Held channel restarts from scratch; its power cycle count is kept
          since_ack_nxt[c] = '0;
          wait_left_nxt[c] = '0;
          reboot_nxt[c]    = 1'b0;
        end else if (inc <= ack_timeout_r) begin
          since_ack_nxt[c] = inc;
        end else if (!reboot_r[c]) begin
          // Timeout: issue a power cycle and start the power-up wait
          since_ack_nxt[c] = inc;
          reboot_nxt[c]    = 1'b1;
          cycle_cnt_nxt[c] = cycle_cnt_r[c] + 1'b1;
          wait_left_nxt[c] = power_wait_r;
          pulse[c]         = 1'b1;
        end else if (wdec == '0) begin
          // Power-up wait has run out
          since_ack_nxt[c] = '0;
          wait_left_nxt[c] = '0;
          reboot_nxt[c]    = 1'b0;
        end else begin
          since_ack_nxt[c] = inc;
          wait_left_nxt[c] = wdec;
        end
      end else if (s1_item_r.msg_len != '0 && !found &&
                   s1_item_r.msg_id == chan_id_r[c]) begin
        // First matching channel in priority order is restarted
        found            = 1'b1;
        which            = ChIdxW'(c);
        since_ack_nxt[c] = '0;
        wait_left_nxt[c] = '0;
        reboot_nxt[c]    = 1'b0;
      end

      // Status after the update
      reb[c]  = reboot_nxt[c];
      away[c] = !reboot_nxt[c] && (since_ack_nxt[c] > away_limit_r);
      cyc[c]  = cycle_cnt_nxt[c];
    end

    out_item_nxt.hb_matched       = found;
    out_item_nxt.hb_channel       = which;
    out_item_nxt.power_cycle_mask = pulse;
    out_item_nxt.rebooting_mask   = reb;
    out_item_nxt.away_mask        = away;
    out_item_nxt.cycles_ch0       = cyc[0];
    out_item_nxt.cycles_ch1       = cyc[1];
    out_item_nxt.cycles_ch2       = cyc[2];
  end

  // State commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reboot_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        since_ack_r[c] <= '0;
        wait_left_r[c] <= '0;
        cycle_cnt_r[c] <= '0;
      end
    end else if (s1_adv) begin
      reboot_r <= reboot_nxt;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        since_ack_r[c] <= since_ack_nxt[c];
        wait_left_r[c] <= wait_left_nxt[c];
        cycle_cnt_r[c] <= cycle_cnt_nxt[c];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  // A channel that just issued a power cycle must report itself rebooting.
  a_pulse_reboot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.power_cycle_mask & ~out_item_r.rebooting_mask) == '0))
    else $error("power cycle pulse without rebooting flag");

  // Rebooting channels are never reported away.
  a_away_reboot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.away_mask & out_item_r.rebooting_mask) == '0))
    else $error("channel reported away while rebooting");

  // A heartbeat match and a power cycle never come from the same request.
  a_match_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.hb_matched) |-> (out_item_r.power_cycle_mask == '0))
    else $error("power cycle on a heartbeat request");

  // A result held under backpressure keeps the reboot flags of the channel state frozen.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(reboot_r))
    else $error("channel state moved while the result was stalled");

  // An empty input stage always accepts a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled while empty");

endmodule
